// File: rtl/ccdrp_pkg.sv
// ----------------------------------------------------------------------------
// ccdrp_pkg
// Shared types, constants and helpers for the cheat-code decoder and patcher.
// ----------------------------------------------------------------------------
package ccdrp_pkg;

  // Limits of the code parser
  localparam int MAX_CODE_CHARS = 15;
  localparam int MIN_CODE_CHARS = 7;
  localparam int CMP_CODE_CHARS = 11;

  // ROM image address space
  localparam int ROM_ADDR_BITS = 23;
  localparam int ROM_OFF_WIDTH = 23;
  localparam int BANK_BITS     = 14;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ROM    = 1'b1;

  // Input item modes
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_ROM  = 1'b1;

  // Special characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Compare scramble: XOR with 0x45 then with 0xFF
  localparam logic [7:0] CMP_XOR = 8'h45 ^ 8'hFF;

  // Slot masks within nibble_ok
  localparam logic [7:0] BASE_SLOTS = 8'h3F;
  localparam logic [7:0] CMP_SLOTS  = 8'hC0;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } slot_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  value;
    logic [14:0] address;
    logic [7:0]  compare;
    logic        cmp_on;
  } decode_t;

  // Map an ASCII hex digit to its nibble
  function automatic hex_t hex_nibble(input logic [7:0] ch);
    hex_t h;
    h.ok  = 1'b0;
    h.nib = ch[3:0];
    if (ch inside {[8'h30:8'h39]}) begin
      h.ok = 1'b1;
    end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.nib = ch[3:0] + 4'd9;
    end
    return h;
  endfunction

  // Nibble slot for a kept-character position
  function automatic slot_t slot_of(input logic [3:0] pos);
    slot_t s;
    s.hit = 1'b1;
    case (pos)
      4'd0:    s.idx = 3'd0;
      4'd1:    s.idx = 3'd1;
      4'd2:    s.idx = 3'd2;
      4'd4:    s.idx = 3'd3;
      4'd5:    s.idx = 3'd4;
      4'd6:    s.idx = 3'd5;
      4'd8:    s.idx = 3'd6;
      4'd10:   s.idx = 3'd7;
      default: begin
        s.hit = 1'b0;
        s.idx = 3'd0;
      end
    endcase
    return s;
  endfunction

endpackage

// File: rtl/ccdrp_parse.sv
// ----------------------------------------------------------------------------
// ccdrp_parse
// Character parser and decoder: keeps the code's hex nibbles and decodes
// value, address and compare byte on the last character.
// ----------------------------------------------------------------------------
module ccdrp_parse
  import ccdrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       last,
  output decode_t    report
);

  logic [3:0] kept_count;
  logic [3:0] kept_count_next;
  logic       code_ended;
  logic       code_ended_next;
  logic [7:0] nibble_ok;
  logic [7:0] nibble_ok_next;
  logic [3:0] code_nibbles [8];
  logic [3:0] code_nibbles_next [8];
  hex_t       hx;
  slot_t      sl;
  logic [7:0] raw_cmp;
  logic       base_ok;
  logic       cmp_ok;

  // Fold the current character into the parse state
  always_comb begin
    kept_count_next   = kept_count;
    code_ended_next   = code_ended;
    nibble_ok_next    = nibble_ok;
    code_nibbles_next = code_nibbles;
    hx = hex_nibble(ch);
    sl = slot_of(kept_count);
    if (!code_ended) begin
      if (ch == CHAR_NUL) begin
        code_ended_next = 1'b1;
      end else if (ch != CHAR_DASH && ch != CHAR_SPACE &&
                   kept_count < 4'(MAX_CODE_CHARS)) begin
        if (sl.hit && hx.ok) begin
          code_nibbles_next[sl.idx] = hx.nib;
          nibble_ok_next[sl.idx]    = 1'b1;
        end
        kept_count_next = kept_count + 4'd1;
      end
    end
  end

  // Decode from the state that includes this character
  assign base_ok = (kept_count_next >= 4'(MIN_CODE_CHARS)) &&
                   ((nibble_ok_next & BASE_SLOTS) == BASE_SLOTS);
  assign cmp_ok  = base_ok && (kept_count_next >= 4'(CMP_CODE_CHARS)) &&
                   ((nibble_ok_next & CMP_SLOTS) == CMP_SLOTS);
  assign raw_cmp = {code_nibbles_next[6], code_nibbles_next[7]};

  always_comb begin
    report = '0;
    if (base_ok) begin
      report.valid   = 1'b1;
      report.value   = {code_nibbles_next[0], code_nibbles_next[1]};
      report.address = {~code_nibbles_next[5][2:0], code_nibbles_next[2],
                        code_nibbles_next[3], code_nibbles_next[4]};
    end
    if (cmp_ok) begin
      report.cmp_on  = 1'b1;
      report.compare = {raw_cmp[1:0], raw_cmp[7:2]} ^ CMP_XOR;
    end
  end

  // Advance the parse state; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      code_ended <= 1'b0;
      nibble_ok  <= '0;
    end else if (step) begin
      if (last) begin
        kept_count <= '0;
        code_ended <= 1'b0;
        nibble_ok  <= '0;
      end else begin
        kept_count <= kept_count_next;
        code_ended <= code_ended_next;
        nibble_ok  <= nibble_ok_next;
      end
    end
  end

  // Hold nibble storage; valid bits guard reads
  always_ff @(posedge clk) begin
    if (step) begin
      code_nibbles <= code_nibbles_next;
    end
  end

`ifndef SYNTHESIS
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= 4'(MAX_CODE_CHARS))
    else $error("kept count beyond code limit");
  a_cmp_needs_valid: assert property (@(posedge clk) disable iff (rst)
    report.cmp_on |-> report.valid)
    else $error("compare reported on invalid code");
`endif

endmodule

// File: rtl/ccdrp_patch.sv
// ----------------------------------------------------------------------------
// ccdrp_patch
// Armed patch registers and the per-byte ROM match and replace.
// ----------------------------------------------------------------------------
module ccdrp_patch
  import ccdrp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     arm_step,
  input  logic                     cheat_enable,
  input  decode_t                  report,
  input  logic [ROM_OFF_WIDTH-1:0] rom_offset,
  input  logic [7:0]               rom_data,
  output logic [7:0]               byte_out,
  output logic                     byte_replaced
);

  localparam logic [ROM_OFF_WIDTH-1:0] ROM_MASK =
    ROM_OFF_WIDTH'((64'd1 << ROM_ADDR_BITS) - 64'd1);

  logic [7:0]               armed_value;
  logic [14:0]              armed_address;
  logic [7:0]               armed_compare;
  logic                     armed_compare_on;
  logic                     patch_armed;
  logic [ROM_OFF_WIDTH-1:0] off_masked;
  logic                     hit;

  // Match the bank offset and the optional compare byte
  assign off_masked    = rom_offset & ROM_MASK;
  assign hit           = patch_armed &&
                         (off_masked[BANK_BITS-1:0] == armed_address[BANK_BITS-1:0]) &&
                         (!armed_compare_on || rom_data == armed_compare);
  assign byte_out      = hit ? armed_value : rom_data;
  assign byte_replaced = hit;

  // Arm on a valid, enabled decode; drop otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_value      <= '0;
      armed_address    <= '0;
      armed_compare    <= '0;
      armed_compare_on <= 1'b0;
      patch_armed      <= 1'b0;
    end else if (arm_step) begin
      if (report.valid && cheat_enable) begin
        armed_value      <= report.value;
        armed_address    <= report.address;
        armed_compare    <= report.compare;
        armed_compare_on <= report.cmp_on;
        patch_armed      <= 1'b1;
      end else begin
        patch_armed <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_patch_unarmed: assert property (@(posedge clk) disable iff (rst)
    !patch_armed |-> !byte_replaced)
    else $error("byte replaced with no patch armed");
  a_arm_follows_enable: assert property (@(posedge clk) disable iff (rst)
    arm_step && !cheat_enable |=> !patch_armed)
    else $error("patch armed while cheats disabled");
`endif

endmodule

// File: rtl/cheat_code_decode_and_rom_patch_core.sv
// ----------------------------------------------------------------------------
// cheat_code_decode_and_rom_patch_core
// Takes one stream beat per cycle: a cheat-code character (tuser 0) or a ROM
// byte with its offset (tuser 1). Characters build up a code; the beat marked
// tlast returns a decode report and, when cheat_enable is set and the code is
// valid, arms it as the one active patch. Every ROM beat returns the byte,
// replaced by the patch value where the low 14 offset bits match the decoded
// address and the compare byte, if any, matches. One beat is accepted per
// cycle outside stalls; each passes an input register and one stage of
// decode/match logic into the output register.
// Intake stalls only while a result waits in the output register.
// ----------------------------------------------------------------------------
module cheat_code_decode_and_rom_patch_core
  import ccdrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] code_char, [30:8] rom_offset, [38:31] rom_data, [39] zero
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // [0] mode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] code_valid, [8:1] patch_value, [23:9] patch_address,
  // [31:24] patch_compare, [32] compare_used, [40:33] byte_out,
  // [41] byte_replaced, [47:42] zero
  output logic [47:0] m_axis_tdata,
  // [0] kind
  output logic        m_axis_tuser
);

  logic                     cheat_enable;
  logic                     in_valid;
  logic                     in_mode;
  logic [7:0]               in_char;
  logic                     in_last;
  logic [ROM_OFF_WIDTH-1:0] in_off;
  logic [7:0]               in_data;
  logic                     out_valid;
  logic                     out_kind;
  decode_t                  out_rep;
  logic [7:0]               out_byte;
  logic                     out_repl;
  logic                     makes_result;
  logic                     stall;
  logic                     advance;
  logic                     char_step;
  decode_t                  report;
  logic [7:0]               patched_byte;
  logic                     patched;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cheat_enable <= 1'b0;
    end else if (cfg_we) begin
      cheat_enable <= cfg_wdata;
    end
  end

  // Handshake: stall only when a result must wait on a full output
  assign makes_result  = (in_mode == MODE_ROM) || in_last;
  assign stall         = in_valid && makes_result && out_valid && !m_axis_tready;
  assign advance       = in_valid && !stall;
  assign s_axis_tready = !in_valid || advance;
  assign char_step     = advance && (in_mode == MODE_CHAR);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode <= s_axis_tuser;
      in_char <= s_axis_tdata[7:0];
      in_last <= s_axis_tlast;
      in_off  <= s_axis_tdata[30:8];
      in_data <= s_axis_tdata[38:31];
    end
  end

  ccdrp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (char_step),
    .ch     (in_char),
    .last   (in_last),
    .report (report)
  );

  ccdrp_patch u_patch (
    .clk           (clk),
    .rst           (rst),
    .arm_step      (char_step && in_last),
    .cheat_enable  (cheat_enable),
    .report        (report),
    .rom_offset    (in_off),
    .rom_data      (in_data),
    .byte_out      (patched_byte),
    .byte_replaced (patched)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && makes_result) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && makes_result) begin
      if (in_mode == MODE_ROM) begin
        out_kind <= KIND_ROM;
        out_rep  <= '0;
        out_byte <= patched_byte;
        out_repl <= patched;
      end else begin
        out_kind <= KIND_REPORT;
        out_rep  <= report;
        out_byte <= '0;
        out_repl <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {6'd0, out_repl, out_byte, out_rep.cmp_on, out_rep.compare,
                          out_rep.address, out_rep.value, out_rep.valid};

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !s_axis_tready |-> out_valid && !m_axis_tready)
    else $error("intake stalled with output free");
  a_rom_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ROM |-> out_rep == '0)
    else $error("decode fields set on ROM result");
  a_report_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_REPORT |-> out_byte == 8'd0 && !out_repl)
    else $error("byte fields set on decode report");
`endif

endmodule

// File: tb/sv/cheat_code_decode_and_rom_patch_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cheat_code_decode_and_rom_patch_core_test
// Drives code-character and ROM-byte beats into the cheat decoder/patcher,
// predicts each decode report and patched byte, and checks every output beat
// in order. Both stream sides idle at random, the enable register is toggled
// between phases, and random cheat codes aim ROM beats at the armed address.
// ----------------------------------------------------------------------------
module cheat_code_decode_and_rom_patch_core_test;
  import ccdrp_pkg::*;

  typedef struct packed {
    logic        kind;
    logic        valid;
    logic [7:0]  value;
    logic [14:0] addr;
    logic [7:0]  cmp;
    logic        cmp_on;
    logic [7:0]  byte_out;
    logic        replaced;
  } patch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Expected output beats, oldest first
  patch_result_t expected_results[$];

  // Predicted block state
  logic        cheat_on = 1'b0;
  int          kept = 0;
  logic        code_done = 1'b0;
  logic [3:0]  nib [8];
  logic [7:0]  nib_ok = '0;
  logic        arm_on = 1'b0;
  logic [7:0]  arm_value = '0;
  logic [14:0] arm_addr = '0;
  logic [7:0]  arm_cmp = '0;
  logic        arm_cmp_on = 1'b0;

  // Run control and tallies
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int n_sent = 0;
  int n_errors = 0;
  int n_reports = 0;
  int n_valid_reports = 0;
  int n_rom = 0;
  int n_replaced = 0;

  cheat_code_decode_and_rom_patch_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hex digit lookup: {ok, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, ch[3:0]};
    if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
      return {1'b1, ch[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // Nibble slot of a kept position, -1 for positions that carry nothing
  function automatic int slot_for(input int pos);
    case (pos)
      0, 1, 2: return pos;
      4, 5, 6: return pos - 1;
      8:       return 6;
      10:      return 7;
      default: return -1;
    endcase
  endfunction

  // Advance the predicted state by one accepted beat, queue any result
  function automatic void predict_beat(input logic mode, input logic [7:0] ch,
                                       input logic last, input logic [22:0] off,
                                       input logic [7:0] data);
    patch_result_t r;
    int            s;
    logic [4:0]    h;
    logic [15:0]   full_addr;
    logic [7:0]    raw;
    r = '0;
    if (mode == MODE_ROM) begin
      r.kind = KIND_ROM;
      r.byte_out = data;
      if (arm_on && off[13:0] == arm_addr[13:0] && (!arm_cmp_on || data == arm_cmp)) begin
        r.byte_out = arm_value;
        r.replaced = 1'b1;
      end
      expected_results.push_back(r);
      return;
    end
    if (!code_done) begin
      if (ch == CHAR_NUL) begin
        code_done = 1'b1;
      end else if (ch != CHAR_DASH && ch != CHAR_SPACE && kept < MAX_CODE_CHARS) begin
        s = slot_for(kept);
        h = hex_digit(ch);
        if (s >= 0 && h[4]) begin
          nib[s] = h[3:0];
          nib_ok[s] = 1'b1;
        end
        kept++;
      end
    end
    if (!last) return;
    // Final character: build the report and arm or drop the patch
    r.kind = KIND_REPORT;
    r.valid = (kept >= MIN_CODE_CHARS) && (nib_ok[5:0] == 6'h3F);
    if (r.valid) begin
      r.value = {nib[0], nib[1]};
      full_addr = {nib[5] ^ 4'hF, nib[2], nib[3], nib[4]};
      r.addr = full_addr[14:0];
      if (kept >= CMP_CODE_CHARS && nib_ok[7:6] == 2'b11) begin
        raw = {nib[6], nib[7]};
        r.cmp = {raw[1:0], raw[7:2]} ^ 8'h45 ^ 8'hFF;
        r.cmp_on = 1'b1;
      end
    end
    if (r.valid && cheat_on) begin
      arm_on = 1'b1;
      arm_value = r.value;
      arm_addr = r.addr;
      arm_cmp = r.cmp;
      arm_cmp_on = r.cmp_on;
    end else begin
      arm_on = 1'b0;
    end
    kept = 0;
    code_done = 1'b0;
    nib_ok = '0;
    expected_results.push_back(r);
  endfunction

  // Send one beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic mode, input logic [7:0] ch, input logic last,
                           input logic [22:0] off, input logic [7:0] data);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {1'b0, data, off, ch};
    do @(posedge clk); while (!s_axis_tready);
    predict_beat(mode, ch, last, off, data);
    n_sent++;
  endtask

  // Character beat: offset and data carry noise
  task automatic send_char(input logic [7:0] ch, input logic last);
    send_beat(MODE_CHAR, ch, last, 23'($urandom), 8'($urandom));
  endtask

  // ROM beat: character and last flag carry noise
  task automatic send_rom(input logic [22:0] off, input logic [7:0] data);
    send_beat(MODE_ROM, 8'($urandom), 1'($urandom), off, data);
  endtask

  // Send a code string, last flag on its final character
  task automatic send_code(input string code);
    for (int i = 0; i < code.len(); i++) send_char(code[i], i == code.len() - 1);
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write cheat_enable while the block is idle
  task automatic set_enable(input logic en);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cheat_on = en;
  endtask

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 5));
      default: return 8'h61 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255));
    while (hex_digit(ch) != 5'd0);
    return ch;
  endfunction

  // Burst of ROM beats, about half aimed at the armed address
  task automatic rom_burst(input int count);
    logic [22:0] off;
    logic [7:0]  data;
    for (int i = 0; i < count; i++) begin
      off  = 23'($urandom);
      data = 8'($urandom);
      if (arm_on && $urandom_range(0, 1)) begin
        off[13:0] = arm_addr[13:0];
        if ($urandom_range(0, 5) == 0) off[$urandom_range(0, 13)] ^= 1'b1;
        if (arm_cmp_on && $urandom_range(0, 2) != 0) data = arm_cmp;
      end
      send_rom(off, data);
    end
  endtask

  // One random code: mostly well formed, some short, bad, overlong or NUL-cut
  task automatic random_code();
    int flavor;
    int n;
    int bad_pos;
    int nul_pos;
    flavor = $urandom_range(0, 9);
    n = $urandom_range(MIN_CODE_CHARS, MAX_CODE_CHARS);
    if (flavor == 6) n = $urandom_range(MAX_CODE_CHARS, 18);
    if (flavor == 7) n = $urandom_range(1, 6);
    bad_pos = $urandom_range(0, n - 1);
    nul_pos = (flavor == 9) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == nul_pos) begin
        send_char(CHAR_NUL, 1'b0);
        repeat ($urandom_range(0, 2)) send_char(rand_hex_char(), 1'b0);
        send_char(8'($urandom), 1'b1);
        return;
      end
      if ((i == 3 || i == 6 || i == 9) && $urandom_range(0, 3) != 0)
        send_char(CHAR_DASH, 1'b0);
      if ($urandom_range(0, 19) == 0) send_char(CHAR_SPACE, 1'b0);
      if ($urandom_range(0, 15) == 0) rom_burst(1);
      if (i == n - 1 && $urandom_range(0, 7) == 0) begin
        send_char(rand_hex_char(), 1'b0);
        send_char($urandom_range(0, 1) ? CHAR_DASH : CHAR_SPACE, 1'b1);
      end else begin
        send_char((flavor == 8 && i == bad_pos) ? rand_bad_char() : rand_hex_char(),
                  i == n - 1);
      end
    end
  endtask

  // ROM beats pass untouched with nothing armed
  task automatic test_unarmed_rom();
    set_enable(1'b0);
    send_rom('0, 8'h00);
    send_rom('1, 8'hFF);
  endtask

  // Code with compare, then a hit in the top bank and a compare miss in bank 0
  task automatic test_decode_and_patch();
    set_enable(1'b1);
    send_code("0aF-3b7-c9E2d");
    send_rom({9'h1FF, arm_addr[13:0]}, arm_cmp);
    send_rom({9'h000, arm_addr[13:0]}, ~arm_cmp);
  endtask

  // Too-short code disarms; NUL ends a code early and later characters drop
  task automatic test_disarm_cases();
    send_code("12");
    send_rom({9'h0AA, arm_addr[13:0]}, arm_cmp);
    send_code("123");
    send_char(CHAR_NUL, 1'b0);
    send_char("4", 1'b1);
  endtask

  // Random phases across enable settings; last phase without idling
  task automatic test_random_traffic();
    int start;
    for (int phase = 0; phase < 8; phase++) begin
      set_enable((phase == 2 || phase == 5) ? 1'b0 : 1'b1);
      tx_idle_on = (phase != 4 && phase != 7);
      rx_idle_on = (phase != 4 && phase != 7);
      start = n_sent;
      while (n_sent - start < 155) begin
        random_code();
        rom_burst($urandom_range(1, 8));
        if (phase == 3 && n_sent - start >= 80 && n_sent - start < 95) wait_drained();
      end
    end
  endtask

  // Compare one field, counting the mismatch
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Check each accepted output beat against the oldest expectation
  always @(posedge clk) begin : check_results
    patch_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%h",
                 $time, m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("code_valid", 32'(want.valid), 32'(m_axis_tdata[0]));
        check_field("patch_value", 32'(want.value), 32'(m_axis_tdata[8:1]));
        check_field("patch_address", 32'(want.addr), 32'(m_axis_tdata[23:9]));
        check_field("patch_compare", 32'(want.cmp), 32'(m_axis_tdata[31:24]));
        check_field("compare_used", 32'(want.cmp_on), 32'(m_axis_tdata[32]));
        check_field("byte_out", 32'(want.byte_out), 32'(m_axis_tdata[40:33]));
        check_field("byte_replaced", 32'(want.replaced), 32'(m_axis_tdata[41]));
        check_field("pad", 32'd0, 32'(m_axis_tdata[47:42]));
        if (want.kind == KIND_ROM) begin
          n_rom++;
          n_replaced += int'(want.replaced);
        end else begin
          n_reports++;
          n_valid_reports += int'(want.valid);
        end
      end
    end
  end

  // Receiver: random stall bursts while enabled
  initial begin
    forever begin
      @(posedge clk);
      if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("FAIL cheat_code_decode_and_rom_patch_core");
    $finish;
  end

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unarmed_rom();
    test_decode_and_patch();
    test_disarm_cases();
    test_random_traffic();
    wait_drained();
    $display("Covered %0d beats: %0d decode reports (%0d valid), %0d ROM bytes (%0d patched)",
             n_sent, n_reports, n_valid_reports, n_rom, n_replaced);
    if (n_errors == 0) begin
      $display("PASS cheat_code_decode_and_rom_patch_core");
    end else begin
      $display("FAIL cheat_code_decode_and_rom_patch_core");
    end
    $finish;
  end

endmodule
